// File: design/aevt_pkg.sv
// Shared types and constants for the angular extreme vector tracker.
`default_nettype none

package aevt_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  localparam logic CFG_BASE_X = 1'b0;
  localparam logic CFG_BASE_Y = 1'b1;

  typedef enum logic [1:0] {
    RANK_OPP   = 2'd0,
    RANK_NEG   = 2'd1,
    RANK_ALONG = 2'd2,
    RANK_POS   = 2'd3
  } rank_e;

endpackage

`default_nettype wire

// File: design/aevt_half_rank.sv
// Half-plane rank of a vector relative to the base direction.
`default_nettype none

module aevt_half_rank #(
  parameter int unsigned W = 16
) (
  input  logic signed [W-1:0] base_x_i,
  input  logic signed [W-1:0] base_y_i,
  input  logic signed [W-1:0] vec_x_i,
  input  logic signed [W-1:0] vec_y_i,
  output aevt_pkg::rank_e     rank_o
);
  import aevt_pkg::*;

  logic signed [2*W-1:0] cross_a;
  logic signed [2*W-1:0] cross_b;
  logic signed [2*W-1:0] dot_a;
  logic signed [2*W-1:0] dot_b;
  logic signed [2*W:0]   dot;

  assign cross_a = base_x_i * vec_y_i;
  assign cross_b = base_y_i * vec_x_i;
  assign dot_a   = base_x_i * vec_x_i;
  assign dot_b   = base_y_i * vec_y_i;
  assign dot     = $signed({dot_a[2*W-1], dot_a}) + $signed({dot_b[2*W-1], dot_b});

  always_comb begin
    if (cross_a > cross_b) begin
      rank_o = RANK_POS;
    end else if (cross_a < cross_b) begin
      rank_o = RANK_NEG;
    end else if (dot > 0) begin
      rank_o = RANK_ALONG;
    end else begin
      rank_o = RANK_OPP;
    end
  end

endmodule

`default_nettype wire

// File: design/aevt_angle_cmp.sv
// Strict angle compare of a new vector against one kept reference vector.
`default_nettype none

module aevt_angle_cmp #(
  parameter int unsigned W = 16
) (
  input  logic signed [W-1:0] base_x_i,
  input  logic signed [W-1:0] base_y_i,
  input  logic signed [W-1:0] vec_x_i,
  input  logic signed [W-1:0] vec_y_i,
  input  aevt_pkg::rank_e     vec_rank_i,
  input  logic signed [W-1:0] ref_x_i,
  input  logic signed [W-1:0] ref_y_i,
  output logic                greater_o
);
  import aevt_pkg::*;

  rank_e                 ref_rank;
  logic signed [2*W-1:0] prod_a;
  logic signed [2*W-1:0] prod_b;
  logic                  same_side;

  aevt_half_rank #(.W(W)) u_ref_rank (
    .base_x_i (base_x_i),
    .base_y_i (base_y_i),
    .vec_x_i  (ref_x_i),
    .vec_y_i  (ref_y_i),
    .rank_o   (ref_rank)
  );

  assign prod_a    = ref_x_i * vec_y_i;
  assign prod_b    = ref_y_i * vec_x_i;
  assign same_side = (vec_rank_i == RANK_NEG) || (vec_rank_i == RANK_POS);

  always_comb begin
    if (vec_rank_i != ref_rank) begin
      greater_o = (vec_rank_i > ref_rank);
    end else begin
      greater_o = same_side && (prod_a > prod_b);
    end
  end

endmodule

`default_nettype wire

// File: design/angular_extreme_vector_tracker_core.sv
// Top level of the angular extreme vector tracker.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one vector per request.
//   Output channel (out_valid_o / out_stall_i) carries the kept leftmost and
//   rightmost vectors after each request, zero while a side holds nothing.
//   The base direction is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while no request is in flight.
// Path: an accepted request loads the input register; its result is valid
//   once the kept-vector registers load from it, which a stalled result delays.
// Throughput: one request per cycle while unstalled; all three ranks, the
//   cross products and the kept-vector update sit in one combinational pass between
//   the input register and the kept-vector registers, which double as the result.
// Reset: base becomes (1, 0), kept vectors clear to zero, no result pending.
// Stall: a stalled result holds; the input register then fills and
//   in_stall_o rises, so no request is lost.
`default_nettype none

module angular_extreme_vector_tracker_core #(
  parameter int unsigned COORD_WIDTH = aevt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic        [COORD_WIDTH-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vec_x_i,
  input  logic signed [COORD_WIDTH-1:0] vec_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] left_x_o,
  output logic signed [COORD_WIDTH-1:0] left_y_o,
  output logic signed [COORD_WIDTH-1:0] right_x_o,
  output logic signed [COORD_WIDTH-1:0] right_y_o
);
  import aevt_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic signed [W-1:0] base_x_q;
  logic signed [W-1:0] base_y_q;
  logic                in_valid_q;
  logic signed [W-1:0] vec_x_q;
  logic signed [W-1:0] vec_y_q;
  logic                out_valid_q;
  logic signed [W-1:0] left_x_q;
  logic signed [W-1:0] left_y_q;
  logic signed [W-1:0] right_x_q;
  logic signed [W-1:0] right_y_q;
  logic                left_taken_q;
  logic                right_taken_q;

  logic                advance;
  logic                in_accept;
  logic                step;
  logic                usable;
  rank_e               vec_rank;
  logic signed [W-1:0] left_ref_x;
  logic signed [W-1:0] left_ref_y;
  logic signed [W-1:0] right_ref_x;
  logic signed [W-1:0] right_ref_y;
  logic                left_greater;
  logic                right_greater;
  logic                upd_left;
  logic                upd_right;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  assign usable = ((vec_x_q != '0) || (vec_y_q != '0)) &&
                  ((base_x_q != '0) || (base_y_q != '0));

  assign left_ref_x  = left_taken_q  ? left_x_q  : base_x_q;
  assign left_ref_y  = left_taken_q  ? left_y_q  : base_y_q;
  assign right_ref_x = right_taken_q ? right_x_q : base_x_q;
  assign right_ref_y = right_taken_q ? right_y_q : base_y_q;

  aevt_half_rank #(.W(W)) u_vec_rank (
    .base_x_i (base_x_q),
    .base_y_i (base_y_q),
    .vec_x_i  (vec_x_q),
    .vec_y_i  (vec_y_q),
    .rank_o   (vec_rank)
  );

  aevt_angle_cmp #(.W(W)) u_left_cmp (
    .base_x_i   (base_x_q),
    .base_y_i   (base_y_q),
    .vec_x_i    (vec_x_q),
    .vec_y_i    (vec_y_q),
    .vec_rank_i (vec_rank),
    .ref_x_i    (left_ref_x),
    .ref_y_i    (left_ref_y),
    .greater_o  (left_greater)
  );

  aevt_angle_cmp #(.W(W)) u_right_cmp (
    .base_x_i   (base_x_q),
    .base_y_i   (base_y_q),
    .vec_x_i    (vec_x_q),
    .vec_y_i    (vec_y_q),
    .vec_rank_i (vec_rank),
    .ref_x_i    (right_ref_x),
    .ref_y_i    (right_ref_y),
    .greater_o  (right_greater)
  );

  assign upd_left  = step && usable && left_greater;
  assign upd_right = step && usable && !right_greater;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= W'(1);
      base_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_X: base_x_q <= cfg_data_i;
        CFG_BASE_Y: base_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      vec_x_q <= vec_x_i;
      vec_y_q <= vec_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_x_q      <= '0;
      left_y_q      <= '0;
      right_x_q     <= '0;
      right_y_q     <= '0;
      left_taken_q  <= 1'b0;
      right_taken_q <= 1'b0;
    end else begin
      if (upd_left) begin
        left_x_q     <= vec_x_q;
        left_y_q     <= vec_y_q;
        left_taken_q <= 1'b1;
      end
      if (upd_right) begin
        right_x_q     <= vec_x_q;
        right_y_q     <= vec_y_q;
        right_taken_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_x_o    = left_x_q;
  assign left_y_o    = left_y_q;
  assign right_x_o   = right_x_q;
  assign right_y_o   = right_y_q;

`ifndef NO_ASSERTIONS
  a_left_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_taken_q |=> left_taken_q)
    else $error("left taken flag dropped");

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_taken_q |-> ((left_x_q != '0) || (left_y_q != '0)))
    else $error("kept left vector is zero");

  a_right_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_taken_q |-> ((right_x_q != '0) || (right_y_q != '0)))
    else $error("kept right vector is zero");

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for angular_extreme_vector_tracker_core: directed table, random phases, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aevt_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE_CYCLES = 6;

  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    coord_t lx;
    coord_t ly;
    coord_t rx;
    coord_t ry;
  } extreme_pair_t;

  typedef enum logic {ROW_VEC, ROW_BASE} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    coord_t        x;
    coord_t        y;
    logic          typed;
    extreme_pair_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   cfg_we_i    = 1'b0;
  logic   cfg_index_i = CFG_BASE_X;
  logic   [W-1:0] cfg_data_i = '0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  coord_t vec_x_i     = '0;
  coord_t vec_y_i     = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  coord_t left_x_o;
  coord_t left_y_o;
  coord_t right_x_o;
  coord_t right_y_o;

  angular_extreme_vector_tracker_core #(
    .COORD_WIDTH(W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .left_x_o   (left_x_o),
    .left_y_o   (left_y_o),
    .right_x_o  (right_x_o),
    .right_y_o  (right_y_o)
  );

  coord_t base_x_q = 16'sd1;
  coord_t base_y_q = 16'sd0;
  coord_t left_x_q = '0;
  coord_t left_y_q = '0;
  coord_t right_x_q = '0;
  coord_t right_y_q = '0;
  bit     left_held = 1'b0;
  bit     right_held = 1'b0;

  extreme_pair_t pending_pairs[$];
  int err_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int base_writes = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_max = 6;
  int stall_span = 0;
  int stall_pct = 0;

  coord_t corners [5] = '{16'sh8000, 16'shFFFF, 16'sd0, 16'sd1, 16'sh7FFF};

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_VEC,  16'sd0,     16'sd0,     1'b1, '0},
    '{ROW_VEC,  16'sd5,     16'sd0,     1'b1, '{16'sd0, 16'sd0, 16'sd5, 16'sd0}},
    '{ROW_VEC,  16'sd0,     16'sd1,     1'b1, '{16'sd0, 16'sd1, 16'sd5, 16'sd0}},
    '{ROW_VEC,  16'shFFFF,  16'sd0,     1'b1, '{16'sd0, 16'sd1, 16'shFFFF, 16'sd0}},
    '{ROW_VEC,  16'sh7FFF,  16'sh7FFF,  1'b0, '0},
    '{ROW_VEC,  16'sh8000,  16'sd1,     1'b0, '0},
    '{ROW_VEC,  16'sh8000,  16'shFFFF,  1'b0, '0},
    '{ROW_VEC,  16'sh8000,  16'sh8000,  1'b0, '0},
    '{ROW_VEC,  16'sh7FFF,  16'sh8000,  1'b0, '0},
    '{ROW_VEC,  16'sh8000,  16'sd0,     1'b0, '0},
    '{ROW_VEC,  16'sh8000,  16'sd1,     1'b0, '0},
    '{ROW_BASE, 16'sd0,     16'sd0,     1'b0, '0},
    '{ROW_VEC,  16'sd100,   16'shFFF9,  1'b0, '0},
    '{ROW_VEC,  16'sd0,     16'sd0,     1'b0, '0},
    '{ROW_BASE, 16'sh8000,  16'sh7FFF,  1'b0, '0},
    '{ROW_VEC,  16'sh8000,  16'sh7FFF,  1'b0, '0},
    '{ROW_VEC,  16'sh7FFF,  16'sh8001,  1'b0, '0},
    '{ROW_VEC,  16'sh7FFF,  16'sh7FFF,  1'b0, '0},
    '{ROW_BASE, 16'sh7FFF,  16'sh8000,  1'b0, '0},
    '{ROW_VEC,  16'shFFFF,  16'shFFFF,  1'b0, '0},
    '{ROW_VEC,  16'sd1,     16'sd1,     1'b0, '0},
    '{ROW_BASE, 16'sd1,     16'sd0,     1'b0, '0},
    '{ROW_VEC,  16'sd1,     16'sd0,     1'b0, '0}
  };

  function automatic int cross_dir(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint p;
    longint q;
    p = longint'(ax) * longint'(by);
    q = longint'(ay) * longint'(bx);
    return (p > q) ? 1 : ((p < q) ? -1 : 0);
  endfunction

  function automatic rank_e half_of(coord_t vx, coord_t vy);
    int     c;
    longint dot;
    c = cross_dir(base_x_q, base_y_q, vx, vy);
    dot = longint'(base_x_q) * longint'(vx) + longint'(base_y_q) * longint'(vy);
    if (c > 0) return RANK_POS;
    if (c < 0) return RANK_NEG;
    return (dot > 0) ? RANK_ALONG : RANK_OPP;
  endfunction

  function automatic int angle_order(coord_t vx, coord_t vy, coord_t ux, coord_t uy);
    rank_e rv;
    rank_e ru;
    rv = half_of(vx, vy);
    ru = half_of(ux, uy);
    if (rv != ru) return (rv > ru) ? 1 : -1;
    if (rv == RANK_NEG || rv == RANK_POS) return cross_dir(ux, uy, vx, vy);
    return 0;
  endfunction

  function automatic extreme_pair_t track_extremes(coord_t vx, coord_t vy);
    coord_t rx;
    coord_t ry;
    coord_t lx;
    coord_t ly;
    logic   go_right;
    logic   go_left;
    if ((vx != 0 || vy != 0) && (base_x_q != 0 || base_y_q != 0)) begin
      rx = right_held ? right_x_q : base_x_q;
      ry = right_held ? right_y_q : base_y_q;
      lx = left_held ? left_x_q : base_x_q;
      ly = left_held ? left_y_q : base_y_q;
      go_right = angle_order(vx, vy, rx, ry) <= 0;
      go_left = angle_order(vx, vy, lx, ly) > 0;
      if (go_right) begin
        right_x_q = vx;
        right_y_q = vy;
        right_held = 1'b1;
      end
      if (go_left) begin
        left_x_q = vx;
        left_y_q = vy;
        left_held = 1'b1;
      end
    end
    return '{left_x_q, left_y_q, right_x_q, right_y_q};
  endfunction

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_base(coord_t x, coord_t y, logic [1:0] which);
    drain_and_settle();
    if (which[0]) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_BASE_X;
      cfg_data_i <= x;
      @(posedge clk_i);
      base_x_q = x;
    end
    if (which[1]) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_BASE_Y;
      cfg_data_i <= y;
      @(posedge clk_i);
      base_y_q = y;
    end
    cfg_we_i <= 1'b0;
    base_writes++;
  endtask

  task automatic send_vec(coord_t x, coord_t y, logic typed, extreme_pair_t want);
    extreme_pair_t pred;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    do @(posedge clk_i); while (in_stall_o || !in_valid_i);
    pred = track_extremes(x, y);
    pending_pairs.push_back(typed ? want : pred);
    accepted_count++;
    burst_left--;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_span <= stall_span - 1;
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin : watch_results
    extreme_pair_t want;
    coord_t        exp_f [4];
    coord_t        got_f [4];
    string         names [4];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pairs.size() == 0) begin
        err_count++;
        $display("%0t: result with no request outstanding: L(%0d,%0d) R(%0d,%0d)",
                 $time, left_x_o, left_y_o, right_x_o, right_y_o);
      end else begin
        want = pending_pairs.pop_front();
        checked_count++;
        exp_f = '{want.lx, want.ly, want.rx, want.ry};
        got_f = '{left_x_o, left_y_o, right_x_o, right_y_o};
        names = '{"left_x", "left_y", "right_x", "right_y"};
        for (int i = 0; i < 4; i++) begin
          if (got_f[i] !== exp_f[i]) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, names[i], exp_f[i], got_f[i]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_pairs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int     pick;
    int     items;
    coord_t vx;
    coord_t vy;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_BASE) begin
        set_base(dir_rows[r].x, dir_rows[r].y, 2'b11);
      end else begin
        send_vec(dir_rows[r].x, dir_rows[r].y, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int phase = 0; phase < 12; phase++) begin
      gap_max = (phase % 3 == 1) ? 0 : 6;
      items = PHASE_ITEMS;
      case (phase)
        0: set_base(16'sd1, 16'sd0, 2'b11);
        1: set_base(16'sh8000, 16'sh7FFF, 2'b11);
        2: set_base(16'sh7FFF, 16'sh8000, 2'b11);
        3: begin
          set_base(16'sd0, 16'sd0, 2'b11);
          items = 30;
        end
        4: set_base(16'sh8000, 16'sh8000, 2'b11);
        5: set_base(16'sd0, corners[$urandom_range(0, 4)], 2'b10);
        default: begin
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            set_base(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)], 2'b11);
          end else begin
            set_base(coord_t'($urandom()), coord_t'($urandom()), 2'(pick));
          end
        end
      endcase

      for (int n = 0; n < items; n++) begin
        if (phase == 6 && n == items / 2) drain_and_settle();
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          vx = coord_t'($urandom());
          vy = coord_t'($urandom());
        end else if (pick < 11) begin
          vx = coord_t'(int'($urandom_range(0, 8)) - 4);
          vy = coord_t'(int'($urandom_range(0, 8)) - 4);
        end else if (pick < 13) begin
          vx = (pick == 11) ? base_x_q : coord_t'(-base_x_q);
          vy = (pick == 11) ? base_y_q : coord_t'(-base_y_q);
        end else if (pick < 15) begin
          vx = (pick == 13) ? left_x_q : right_x_q;
          vy = (pick == 13) ? left_y_q : right_y_q;
        end else if (pick < 18) begin
          vx = corners[$urandom_range(0, 4)];
          vy = corners[$urandom_range(0, 4)];
        end else if (pick == 18) begin
          vx = '0;
          vy = '0;
        end else begin
          vx = coord_t'(-left_x_q);
          vy = coord_t'(-left_y_q);
        end
        send_vec(vx, vy, 1'b0, '0);
      end
    end

    drain_and_settle();
    $display("Sent %0d vectors over %0d base settings, %0d results checked,", accepted_count,
             base_writes, checked_count);
    $display("with sender bursts, receiver stalls, zero vectors, zero base and ties.");
    if (err_count == 0 && pending_pairs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/aevt_pkg.sv
design/aevt_half_rank.sv
design/aevt_angle_cmp.sv
design/angular_extreme_vector_tracker_core.sv
dv/tb_top.sv
